// File: rtl/dscg_pkg.sv
// shared types, constants and register map for the density stretch colormap unit
// no dependencies
package dscg_pkg;

  localparam int MAX_CELLS = 256;
  localparam int ADDR_W    = $clog2(MAX_CELLS);
  localparam int CNT_W     = $clog2(MAX_CELLS + 1);
  localparam int PADDR_W   = 5;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam int DIV_STEPS  = 32;
  localparam int SQ_STEPS   = 16;
  localparam int EXP_BITS   = 16;
  localparam int SQRT_STEPS = 31;

  localparam logic [15:0] CLIP_HIGH_RST = 16'hFFFF;
  localparam logic [15:0] GAMMA_RST     = 16'd2867;
  localparam logic [15:0] GAIN_RST      = 16'd6144;

  typedef enum logic [2:0] {
    REG_AUTO_RANGE   = 3'd0,
    REG_CLIP_LOW     = 3'd1,
    REG_CLIP_HIGH    = 3'd2,
    REG_LEVEL_BIAS   = 3'd3,
    REG_GAMMA        = 3'd4,
    REG_GAIN         = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic               auto_range;
    logic [15:0]        clip_low;
    logic [15:0]        clip_high;
    logic signed [16:0] level_bias;
    logic [15:0]        gamma_exponent;
    logic [15:0]        output_gain;
  } cfg_t;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_LOAD,
    DP_READ,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_NORM,
    DP_SET_ONE,
    DP_SET_ZERO,
    DP_LOG_INIT,
    DP_SQ_STEP,
    DP_MAG,
    DP_EXP_BIT,
    DP_SQRT_STEP,
    DP_SQRT_END,
    DP_SCALE,
    DP_GAIN,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    logic can_emit;
    logic cell_missing;
    logic v_one;
    logic v_zero;
    logic gamma_zero;
    logic q_big;
  } dp_stat_t;

endpackage

// File: rtl/dscg_stream_if.sv
// valid/ready stream interfaces for the input and result channels
// no dependencies
interface dscg_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] sample;
  logic        is_missing;
  logic        last_sample;

  modport source (output valid, op, sample, is_missing, last_sample, input ready);
  modport sink (input valid, op, sample, is_missing, last_sample, output ready);
endinterface

interface dscg_out_if;
  logic        valid;
  logic        ready;
  logic        present;
  logic [7:0]  marker_number;
  logic [7:0]  cell_index;
  logic [15:0] red_level;
  logic [15:0] blue_level;
  logic        last_cell;

  modport source (output valid, present, marker_number, cell_index, red_level, blue_level,
                  last_cell, input ready);
  modport sink (input valid, present, marker_number, cell_index, red_level, blue_level,
                last_cell, output ready);
endinterface

// File: rtl/dscg_datapath.sv
// cell store, frame counters, divider, log2/exp2 gamma unit and result register
// depends on dscg_pkg
module dscg_datapath import dscg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  dp_op_t      cmd,
  input  logic [15:0] in_sample,
  input  logic        in_missing,
  input  logic        in_last,
  output dp_stat_t    stat,
  output logic        out_present,
  output logic [7:0]  out_marker,
  output logic [7:0]  out_index,
  output logic [15:0] out_red,
  output logic [15:0] out_blue,
  output logic        out_last
);

  logic [16:0]      mem [MAX_CELLS];
  logic [CNT_W-1:0] cells_loaded;
  logic [CNT_W-1:0] ptr;
  logic [15:0]      run_min;
  logic [15:0]      run_max;
  logic [CNT_W-1:0] marker_count;
  logic             frame_closed;

  logic [16:0]      cur_cell;
  logic [CNT_W-1:0] idx;
  logic             last_f;
  logic [15:0]      span;
  logic             neg;
  logic [15:0]      rem;
  logic [31:0]      dq;
  logic [16:0]      v;
  logic [3:0]       kreg;
  logic [30:0]      mant;
  logic [15:0]      frac;
  logic [8:0]       q;
  logic [15:0]      f;
  logic [30:0]      y;
  logic [61:0]      x;
  logic [32:0]      srem;
  logic [30:0]      root;

  logic [CNT_W-1:0] base_cnt;
  logic [15:0]      min_base;
  logic [15:0]      max_base;
  logic             store_ok;

  assign base_cnt = frame_closed ? '0 : cells_loaded;
  assign min_base = frame_closed ? 16'hFFFF : run_min;
  assign max_base = frame_closed ? 16'h0000 : run_max;
  assign store_ok = base_cnt < CNT_W'(MAX_CELLS);

  // stretch limits and divider operands
  logic [15:0]        lo;
  logic [15:0]        hi;
  logic signed [16:0] span_raw;
  logic [15:0]        span_c;
  logic signed [16:0] diff;
  logic [16:0]        diff_neg;
  logic [15:0]        diff_abs;

  always_comb begin
    if (cfg.auto_range) begin
      if (run_max <= run_min) begin
        lo = 16'h0000;
        hi = 16'hFFFF;
      end else begin
        lo = run_min;
        hi = run_max;
      end
    end else begin
      lo = cfg.clip_low;
      hi = cfg.clip_high;
    end
  end

  assign span_raw = $signed({1'b0, hi}) - $signed({1'b0, lo});
  assign span_c   = (span_raw < 17'sd1) ? 16'd1 : span_raw[15:0];
  assign diff     = $signed({1'b0, cur_cell[15:0]}) - $signed({1'b0, lo});
  assign diff_neg = 17'(-diff);
  assign diff_abs = diff[16] ? diff_neg[15:0] : diff[15:0];

  logic [16:0] rem_s;
  logic        rem_ge;
  assign rem_s  = {rem, dq[31]};
  assign rem_ge = rem_s >= {1'b0, span};

  logic signed [34:0] n_q;
  logic signed [34:0] n_b;
  assign n_q = neg ? -$signed({3'b000, dq}) : $signed({3'b000, dq});
  assign n_b = n_q - {{18{cfg.level_bias[16]}}, cfg.level_bias};

  // leading one of the normalized value
  logic [3:0] k;
  always_comb begin
    k = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) k = 4'(i);
    end
  end

  logic [30:0] v_wide;
  logic [61:0] sq_prod;
  logic [31:0] sq_t;
  assign v_wide  = {15'b0, v[15:0]};
  assign sq_prod = mant * mant;
  assign sq_t    = sq_prod[61:30];

  logic [20:0] mag;
  logic [36:0] mag_prod;
  assign mag      = {5'd16 - {1'b0, kreg}, 16'b0} - {5'b0, frac};
  assign mag_prod = mag * cfg.gamma_exponent;

  logic [30:0] y_half;
  assign y_half = f[0] ? (y >> 1) : y;

  logic [34:0] sq_rem_s;
  logic [34:0] sq_trial;
  assign sq_rem_s = {srem, x[61:60]};
  assign sq_trial = {2'b00, root, 2'b01};

  logic [32:0] gain_prod;
  logic [20:0] gain_w;
  assign gain_prod = v * cfg.output_gain;
  assign gain_w    = gain_prod[32:12];

  logic [16:0] blue_full;
  assign blue_full = ONE_Q16 - v;

  always_comb begin
    stat.can_emit     = frame_closed && (ptr < cells_loaded);
    stat.cell_missing = cur_cell[16];
    stat.v_one        = v[16];
    stat.v_zero       = v == 17'd0;
    stat.gamma_zero   = cfg.gamma_exponent == 16'd0;
    stat.q_big        = q > 9'd16;
  end

  // frame bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      cells_loaded <= '0;
      ptr          <= '0;
      run_min      <= 16'hFFFF;
      run_max      <= 16'h0000;
      marker_count <= '0;
      frame_closed <= 1'b0;
    end else begin
      case (cmd)
        DP_LOAD: begin
          if (frame_closed) begin
            ptr          <= '0;
            marker_count <= '0;
          end
          cells_loaded <= store_ok ? CNT_W'(base_cnt + 1'b1) : base_cnt;
          run_min      <= (store_ok && !in_missing && in_sample < min_base) ?
                          in_sample : min_base;
          run_max      <= (store_ok && !in_missing && in_sample > max_base) ?
                          in_sample : max_base;
          frame_closed <= in_last;
        end
        DP_READ: begin
          ptr <= ptr + 1'b1;
        end
        DP_OUT: begin
          if (!cur_cell[16]) marker_count <= marker_count + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == DP_LOAD && store_ok) mem[base_cnt[ADDR_W-1:0]] <= {in_missing, in_sample};
    if (cmd == DP_READ) cur_cell <= mem[ptr[ADDR_W-1:0]];
  end

  // arithmetic
  always_ff @(posedge clk) begin
    case (cmd)
      DP_READ: begin
        idx    <= ptr;
        last_f <= (ptr + 1'b1) == cells_loaded;
      end
      DP_DIV_INIT: begin
        span <= span_c;
        neg  <= diff[16];
        rem  <= 16'd0;
        dq   <= {diff_abs, 16'b0};
      end
      DP_DIV_STEP: begin
        rem <= rem_ge ? 16'(rem_s - {1'b0, span}) : rem_s[15:0];
        dq  <= {dq[30:0], rem_ge};
      end
      DP_NORM: begin
        if (n_b < 35'sd0) v <= 17'd0;
        else if (n_b > 35'sd65536) v <= ONE_Q16;
        else v <= n_b[16:0];
      end
      DP_SET_ONE: v <= ONE_Q16;
      DP_SET_ZERO: v <= 17'd0;
      DP_LOG_INIT: begin
        kreg <= k;
        mant <= v_wide << (5'd30 - {1'b0, k});
        frac <= 16'd0;
      end
      DP_SQ_STEP: begin
        if (sq_t[31]) begin
          mant <= sq_t[31:1];
          frac <= {frac[14:0], 1'b1};
        end else begin
          mant <= sq_t[30:0];
          frac <= {frac[14:0], 1'b0};
        end
      end
      DP_MAG: begin
        q <= mag_prod[36:28];
        f <= mag_prod[27:12];
        y <= 31'h4000_0000;
      end
      DP_EXP_BIT: begin
        x    <= {1'b0, y_half, 30'b0};
        f    <= f >> 1;
        srem <= 33'd0;
        root <= 31'd0;
      end
      DP_SQRT_STEP: begin
        if (sq_rem_s >= sq_trial) begin
          srem <= 33'(sq_rem_s - sq_trial);
          root <= {root[29:0], 1'b1};
        end else begin
          srem <= sq_rem_s[32:0];
          root <= {root[29:0], 1'b0};
        end
        x <= x << 2;
      end
      DP_SQRT_END: y <= root;
      DP_SCALE: v <= 17'(y >> (q[4:0] + 5'd14));
      DP_GAIN: v <= (gain_w > 21'(ONE_Q16)) ? ONE_Q16 : gain_w[16:0];
      DP_OUT: begin
        out_index <= 8'(idx);
        out_last  <= last_f;
        if (!cur_cell[16]) begin
          out_present <= 1'b1;
          out_marker  <= 8'(marker_count);
          out_red     <= v[16] ? 16'hFFFF : v[15:0];
          out_blue    <= blue_full[16] ? 16'hFFFF : blue_full[15:0];
        end else begin
          out_present <= 1'b0;
          out_marker  <= 8'd0;
          out_red     <= 16'd0;
          out_blue    <= 16'd0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/dscg_ctrl.sv
// sequencer for load, readout and the per-cell mapping steps
// depends on dscg_pkg
module dscg_ctrl import dscg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_op_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIV, S_NORM, S_GSEL, S_SQ, S_MAG, S_QCHK,
    S_EXP, S_SQRT, S_SQRT_END, S_SCALE, S_GAIN, S_FIN
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [3:0] bit_cnt, bit_cnt_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd          = DP_NONE;
    state_next   = state;
    cnt_next     = cnt;
    bit_cnt_next = bit_cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_op) begin
            cmd = DP_LOAD;
          end else if (stat.can_emit) begin
            cmd        = DP_READ;
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.cell_missing) begin
          state_next = S_FIN;
        end else begin
          cmd        = DP_DIV_INIT;
          cnt_next   = 5'd0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd      = DP_DIV_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == 5'(DIV_STEPS - 1)) state_next = S_NORM;
      end
      S_NORM: begin
        cmd        = DP_NORM;
        state_next = S_GSEL;
      end
      S_GSEL: begin
        if (stat.v_one || stat.gamma_zero) begin
          cmd        = DP_SET_ONE;
          state_next = S_GAIN;
        end else if (stat.v_zero) begin
          state_next = S_GAIN;
        end else begin
          cmd        = DP_LOG_INIT;
          cnt_next   = 5'd0;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd      = DP_SQ_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == 5'(SQ_STEPS - 1)) state_next = S_MAG;
      end
      S_MAG: begin
        cmd        = DP_MAG;
        state_next = S_QCHK;
      end
      S_QCHK: begin
        if (stat.q_big) begin
          cmd        = DP_SET_ZERO;
          state_next = S_GAIN;
        end else begin
          bit_cnt_next = 4'd0;
          state_next   = S_EXP;
        end
      end
      S_EXP: begin
        cmd        = DP_EXP_BIT;
        cnt_next   = 5'd0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd      = DP_SQRT_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == 5'(SQRT_STEPS - 1)) state_next = S_SQRT_END;
      end
      S_SQRT_END: begin
        cmd = DP_SQRT_END;
        if (bit_cnt == 4'(EXP_BITS - 1)) begin
          state_next = S_SCALE;
        end else begin
          bit_cnt_next = bit_cnt + 1'b1;
          state_next   = S_EXP;
        end
      end
      S_SCALE: begin
        cmd        = DP_SCALE;
        state_next = S_GAIN;
      end
      S_GAIN: begin
        cmd        = DP_GAIN;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd        = DP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= 5'd0;
      bit_cnt   <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      bit_cnt <= bit_cnt_next;
      if (state == S_FIN && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> out_valid)
    else $error("result not presented after finish");

  a_sq_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ) |-> (cnt < 5'(SQ_STEPS)))
    else $error("squaring count out of range");

  a_exp_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT_END && bit_cnt == 4'(EXP_BITS - 1)) |=> (state == S_SCALE))
    else $error("exp2 sequence overran");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (cmd != DP_LOAD && cmd != DP_READ))
    else $error("store touched while busy");

endmodule

// File: rtl/density_stretch_gamma_colormap_unit.sv
// density contrast stretch, gamma and heat map unit: top level with apb registers
// depends on dscg_pkg, dscg_stream_if, dscg_ctrl, dscg_datapath
//
// in_ch carries load beats (op 0) and emit beats (op 1); out_ch carries one
// result per emit of a stored cell. a load beat gives no result. an emit beat
// reads the next cell of the closed frame and gives a result: for a present
// cell after a 32-step divider, 16 squarings for log2, then 16 exp2 bits each
// with a 31-step square root, unless the gamma steps are skipped, and for a
// missing cell with no arithmetic. emits before the frame closes or past its
// end give no result. one item is worked on at a time: a new beat is taken
// only once the last result sits in the output register. the next beat is
// taken while that result waits there, and a stalled receiver only holds the
// unit at the finish. configuration goes through the apb port; the user must
// write it only while the unit is idle, as the block does not enforce this.
// reset (synchronous, rst high) clears the frame counters and registers to
// their defaults; the store needs no clearing.
module density_stretch_gamma_colormap_unit import dscg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  dscg_in_if.sink            in_ch,
  dscg_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t     cfg;
  dp_op_t   cmd;
  dp_stat_t stat;
  reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_range     <= 1'b0;
      cfg.clip_low       <= 16'd0;
      cfg.clip_high      <= CLIP_HIGH_RST;
      cfg.level_bias     <= 17'sd0;
      cfg.gamma_exponent <= GAMMA_RST;
      cfg.output_gain    <= GAIN_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_AUTO_RANGE:   cfg.auto_range     <= pwdata[0];
        REG_CLIP_LOW:     cfg.clip_low       <= pwdata[15:0];
        REG_CLIP_HIGH:    cfg.clip_high      <= pwdata[15:0];
        REG_LEVEL_BIAS:   cfg.level_bias     <= $signed(pwdata[16:0]);
        REG_GAMMA:        cfg.gamma_exponent <= pwdata[15:0];
        REG_GAIN:         cfg.output_gain    <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_AUTO_RANGE:   prdata = {31'b0, cfg.auto_range};
      REG_CLIP_LOW:     prdata = {16'b0, cfg.clip_low};
      REG_CLIP_HIGH:    prdata = {16'b0, cfg.clip_high};
      REG_LEVEL_BIAS:   prdata = {15'b0, cfg.level_bias};
      REG_GAMMA:        prdata = {16'b0, cfg.gamma_exponent};
      REG_GAIN:         prdata = {16'b0, cfg.output_gain};
      default:          prdata = 32'd0;
    endcase
  end

  dscg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dscg_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .in_sample   (in_ch.sample),
    .in_missing  (in_ch.is_missing),
    .in_last     (in_ch.last_sample),
    .stat        (stat),
    .out_present (out_ch.present),
    .out_marker  (out_ch.marker_number),
    .out_index   (out_ch.cell_index),
    .out_red     (out_ch.red_level),
    .out_blue    (out_ch.blue_level),
    .out_last    (out_ch.last_cell)
  );

endmodule

// File: sim/testbench.sv
// testbench for density_stretch_gamma_colormap_unit: random frames of load and emit beats
// depends on dscg_pkg, dscg_stream_if and the rtl top level; predicts every result in a scoreboard
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dscg_pkg::*;

  typedef struct packed {
    logic        present;
    logic [7:0]  marker_number;
    logic [7:0]  cell_index;
    logic [15:0] red_level;
    logic [15:0] blue_level;
    logic        last_cell;
  } marker_t;

  class colormap_scoreboard;
    cfg_t        cfg;
    logic [16:0] cells[MAX_CELLS];
    int unsigned n_loaded, rd_ptr, markers;
    logic [15:0] lo_seen, hi_seen;
    bit          closed;
    marker_t     markers_due[$];
    int          errors;

    function new();
      cfg = '{auto_range: 1'b0, clip_low: 16'd0, clip_high: CLIP_HIGH_RST,
              level_bias: 17'sd0, gamma_exponent: GAMMA_RST, output_gain: GAIN_RST};
      errors = 0;
      restart();
    endfunction

    function void restart();
      n_loaded = 0; rd_ptr = 0; markers = 0;
      lo_seen = 16'hFFFF; hi_seen = 16'h0; closed = 0;
    endfunction

    function longint unsigned isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint unsigned gamma_pow(longint unsigned v);
      int k;
      int unsigned q;
      longint unsigned mant, frac, mag, m, f, y;
      if (v >= 65536 || cfg.gamma_exponent == 0) return 65536;
      if (v == 0) return 0;
      k = 0;
      while ((v >> (k + 1)) != 0) k++;
      mant = v << (30 - k);
      frac = 0;
      for (int i = 0; i < 16; i++) begin
        mant = (mant * mant) >> 30;
        frac <<= 1;
        if (mant >= (64'd1 << 31)) begin
          frac |= 1;
          mant >>= 1;
        end
      end
      mag = longint'(16 - k) * 65536 - frac;
      m = (mag * cfg.gamma_exponent) >> 12;
      q = 32'(m >> 16);
      if (q > 16) return 0;
      f = m & 64'hFFFF;
      y = 64'd1 << 30;
      for (int i = 0; i < 16; i++) begin
        if ((f >> i) & 1) y >>= 1;
        y = isqrt(y << 30);
      end
      return y >> (q + 14);
    endfunction

    function longint unsigned map_density(logic [15:0] d);
      longint lo, hi, span, n;
      longint unsigned w;
      if (cfg.auto_range) begin
        if (hi_seen <= lo_seen) begin
          lo = 0; hi = 65535;
        end else begin
          lo = lo_seen; hi = hi_seen;
        end
      end else begin
        lo = cfg.clip_low; hi = cfg.clip_high;
      end
      span = hi - lo;
      if (span < 1) span = 1;
      n = ((longint'(d) - lo) * 65536) / span;
      n -= longint'(cfg.level_bias);
      if (n < 0) n = 0;
      if (n > 65536) n = 65536;
      w = (gamma_pow(n) * cfg.output_gain) >> 12;
      if (w > 65536) w = 65536;
      return w;
    endfunction

    function void note_beat(logic op, logic [15:0] sample, logic miss, logic last);
      marker_t r;
      longint unsigned v;
      if (!op) begin
        if (closed) restart();
        if (n_loaded < MAX_CELLS) begin
          cells[n_loaded] = {miss, sample};
          n_loaded++;
          if (!miss) begin
            if (sample < lo_seen) lo_seen = sample;
            if (sample > hi_seen) hi_seen = sample;
          end
        end
        if (last) closed = 1;
        return;
      end
      if (!closed || rd_ptr >= n_loaded) return;
      r = '0;
      r.cell_index = rd_ptr[7:0];
      r.last_cell = (rd_ptr + 1 == n_loaded);
      if (!cells[rd_ptr][16]) begin
        v = map_density(cells[rd_ptr][15:0]);
        r.present = 1;
        r.marker_number = markers[7:0];
        r.red_level = (v > 65535) ? 16'hFFFF : v[15:0];
        r.blue_level = (65536 - v > 65535) ? 16'hFFFF : 16'(65536 - v);
        markers = (markers + 1) & 9'h1FF;
      end
      rd_ptr++;
      markers_due = {markers_due, r};
    endfunction

    function void check_beat(marker_t got);
      marker_t e;
      if (markers_due.size() == 0) begin
        $error("unexpected result beat, cell_index %0d", got.cell_index);
        errors++;
        return;
      end
      e = markers_due.pop_front();
      if (got.present !== e.present) begin
        $error("present exp %0d got %0d", e.present, got.present); errors++;
      end
      if (got.marker_number !== e.marker_number) begin
        $error("marker_number exp %0d got %0d", e.marker_number, got.marker_number); errors++;
      end
      if (got.cell_index !== e.cell_index) begin
        $error("cell_index exp %0d got %0d", e.cell_index, got.cell_index); errors++;
      end
      if (got.red_level !== e.red_level) begin
        $error("red_level exp %0d got %0d", e.red_level, got.red_level); errors++;
      end
      if (got.blue_level !== e.blue_level) begin
        $error("blue_level exp %0d got %0d", e.blue_level, got.blue_level); errors++;
      end
      if (got.last_cell !== e.last_cell) begin
        $error("last_cell exp %0d got %0d", e.last_cell, got.last_cell); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  dscg_in_if in_ch();
  dscg_out_if out_ch();

  density_stretch_gamma_colormap_unit DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  colormap_scoreboard sb = new();
  int burst_left = 0;
  int beats_sent = 0;
  bit hold_req = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    in_ch.valid = 0; in_ch.op = 0; in_ch.sample = '0;
    in_ch.is_missing = 0; in_ch.last_sample = 0;
  end

  // receiver: changing stall pattern plus one long hold-off on request
  initial begin
    int hold_cnt, mode_cnt, mode;
    hold_cnt = 0; mode_cnt = 0; mode = 0;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = 3000;
      end
      if (mode_cnt == 0) begin
        mode = $urandom_range(0, 3);
        mode_cnt = $urandom_range(50, 2000);
      end
      mode_cnt--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready = 0;
      end else begin
        case (mode)
          0: out_ch.ready = 1;
          1: out_ch.ready = $urandom_range(0, 1);
          2: out_ch.ready = ($urandom_range(0, 3) == 0);
          default: out_ch.ready = ((mode_cnt % 7) < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_beat({out_ch.present, out_ch.marker_number, out_ch.cell_index,
                     out_ch.red_level, out_ch.blue_level, out_ch.last_cell});
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel = 1; pwrite = 1; penable = 0;
    paddr = PADDR_W'({idx, 2'b00}); pwdata = val;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    case (idx)
      REG_AUTO_RANGE:   sb.cfg.auto_range = val[0];
      REG_CLIP_LOW:     sb.cfg.clip_low = val[15:0];
      REG_CLIP_HIGH:    sb.cfg.clip_high = val[15:0];
      REG_LEVEL_BIAS:   sb.cfg.level_bias = val[16:0];
      REG_GAMMA:        sb.cfg.gamma_exponent = val[15:0];
      default:          sb.cfg.output_gain = val[15:0];
    endcase
  endtask

  task automatic send_beat(logic op, logic [15:0] sample, logic miss, logic last);
    if (burst_left == 0) begin
      if (in_ch.valid) begin
        @(negedge clk);
        in_ch.valid = 0;
      end
      repeat ($urandom_range(0, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    @(negedge clk);
    in_ch.valid = 1; in_ch.op = op; in_ch.sample = sample;
    in_ch.is_missing = miss; in_ch.last_sample = last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_beat(op, sample, miss, last);
    burst_left--;
    beats_sent++;
  endtask

  task automatic drain();
    if (in_ch.valid) begin
      @(negedge clk);
      in_ch.valid = 0;
    end
    burst_left = 0;
    while (sb.markers_due.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  function automatic logic [31:0] pick16();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'd65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic send_frame(int n, int miss_pct, int extra_emits, bit partial);
    int reads;
    for (int i = 0; i < n; i++)
      send_beat(1'b0, 16'($urandom_range(0, 65535)), $urandom_range(0, 99) < miss_pct,
                i == n - 1);
    reads = (n > MAX_CELLS ? MAX_CELLS : n) + extra_emits;
    if (partial) reads = $urandom_range(0, reads);
    repeat (reads) send_beat(1'b1, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
  endtask

  initial begin
    int phase;
    logic [31:0] b;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: extremes, missing cells, early and late emits
    send_beat(1'b1, 16'hFFFF, 1'b0, 1'b0);
    send_beat(1'b0, 16'h0000, 1'b0, 1'b0);
    send_beat(1'b0, 16'hFFFF, 1'b0, 1'b0);
    send_beat(1'b1, 16'h0, 1'b0, 1'b0);
    send_beat(1'b0, 16'hFFFF, 1'b1, 1'b0);
    send_beat(1'b0, 16'd30000, 1'b0, 1'b1);
    repeat (5) send_beat(1'b1, 16'h0, 1'b0, 1'b0);
    drain();
    reg_write(REG_AUTO_RANGE, 32'd1);
    reg_write(REG_GAMMA, 32'd0);
    send_beat(1'b0, 16'd5, 1'b1, 1'b0);
    send_beat(1'b0, 16'd9, 1'b1, 1'b1);
    repeat (2) send_beat(1'b1, 16'h0, 1'b0, 1'b0);
    send_beat(1'b0, 16'd777, 1'b0, 1'b1);
    send_beat(1'b1, 16'h0, 1'b0, 1'b0);
    drain();
    reg_write(REG_AUTO_RANGE, 32'd0);
    reg_write(REG_CLIP_LOW, 32'd40000);
    reg_write(REG_CLIP_HIGH, 32'd100);
    reg_write(REG_LEVEL_BIAS, 32'h1_0001);
    reg_write(REG_GAMMA, 32'd65535);
    reg_write(REG_GAIN, 32'd65535);
    send_beat(1'b0, 16'd0, 1'b0, 1'b0);
    send_beat(1'b0, 16'd40001, 1'b0, 1'b1);
    repeat (2) send_beat(1'b1, 16'h0, 1'b0, 1'b0);

    phase = 0;
    while (beats_sent < 1850) begin
      drain();
      reg_write(REG_AUTO_RANGE, $urandom_range(0, 1));
      reg_write(REG_CLIP_LOW, pick16());
      reg_write(REG_CLIP_HIGH, pick16());
      case ($urandom_range(0, 4))
        0: b = 32'h1_0001;
        1: b = 32'd65535;
        2: b = 32'd0;
        default: b = $urandom_range(0, 32'h1_FFFF);
      endcase
      if (b[16:0] == 17'h1_0000) b = 32'h1_0001;
      reg_write(REG_LEVEL_BIAS, b & 32'h1_FFFF);
      reg_write(REG_GAMMA, ($urandom_range(0, 2) == 0) ? pick16() : $urandom_range(0, 12000));
      reg_write(REG_GAIN, ($urandom_range(0, 2) == 0) ? pick16() : $urandom_range(2048, 8192));
      if (phase == 2) hold_req = 1;
      if (phase == 4) begin
        send_frame(300, 95, 2, 0);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 9) == 0)
            send_beat(1'b1, 16'($urandom_range(0, 65535)), 1'b0, 1'b0);
          send_frame($urandom_range(1, 10), $urandom_range(0, 40),
                     $urandom_range(0, 1), $urandom_range(0, 6) == 0);
        end
      end
      phase++;
    end
    drain();
    if (sb.errors == 0 && sb.markers_due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("testbench NOT OK");
    $finish;
  end
endmodule
